// ----- hdl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared clocked assertion forms for the marker parser RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- hdl/jmsp_pkg.sv -----
// ============================================================================
// jmsp_pkg
// Types, codes and defaults shared by the JPEG marker segment parser.
// ============================================================================
package jmsp_pkg;

    // Parameter defaults.
    localparam int PREFIX_BYTES_DEF = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    // Configuration reset values.
    localparam logic [31:0] FILE_SIZE_RST    = 32'd0;
    localparam logic [15:0] MAX_FILL_RST     = 16'd64;
    localparam logic [15:0] MAX_SEGMENTS_RST = 16'd256;

    // Marker bytes.
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;

    // Length field counts its own two bytes.
    localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

    typedef enum logic [1:0] {
        CFG_FILE_SIZE    = 2'd0,
        CFG_MAX_FILL     = 2'd1,
        CFG_MAX_SEGMENTS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_CODE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PREFIX = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_NOT_JPEG  = 2'd3
    } t_status;

    // One input beat.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_data;
    } t_in_item;

    // Current configuration and the restart strobe.
    typedef struct packed {
        logic [31:0] file_size;
        logic [15:0] max_fill;
        logic [15:0] max_segments;
        logic        restart;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  marker_code;
        logic [31:0] marker_offset;
        logic [15:0] fill_count;
        logic        is_standalone;
        logic [15:0] payload_length;
        logic [31:0] payload_offset;
        logic [31:0] scan_length;
        logic [7:0]  prefix_byte;
        logic        last_of_segment;
        t_status     status;
        logic [15:0] segment_index;
    } t_result;

endpackage

// ----- hdl/jmsp_cfg.sv -----
// ============================================================================
// jmsp_cfg
// Configuration registers; a file_size write also strobes a parse restart.
// ============================================================================
module jmsp_cfg
    import jmsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    logic [31:0] r_file_size;
    logic [15:0] r_max_fill;
    logic [15:0] r_max_segments;
    logic        restart;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size    <= FILE_SIZE_RST;
            r_max_fill     <= MAX_FILL_RST;
            r_max_segments <= MAX_SEGMENTS_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILE_SIZE:    r_file_size    <= i_cfg_data;
                CFG_MAX_FILL:     r_max_fill     <= i_cfg_data[15:0];
                CFG_MAX_SEGMENTS: r_max_segments <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The parser restarts in the same edge that takes the new file size.
    assign restart = i_cfg_valid && (t_cfg_idx'(i_cfg_index) == CFG_FILE_SIZE);

    assign o_cfg.file_size    = r_file_size;
    assign o_cfg.max_fill     = r_max_fill;
    assign o_cfg.max_segments = r_max_segments;
    assign o_cfg.restart      = restart;

endmodule

// ----- hdl/jmsp_parser.sv -----
// ============================================================================
// jmsp_parser
// Parse state, one-byte step logic and the result register.
// ============================================================================
`include "assert_macros.svh"

module jmsp_parser
    import jmsp_pkg::*;
#(
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_item_valid,
    input  t_in_item i_item,
    output logic     o_item_ready,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    localparam int PW = $clog2(PREFIX_BYTES + 1);
    localparam int CW = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;
    localparam logic [PW-1:0]  PREFIX_CNT = PW'(PREFIX_BYTES);
    localparam logic [15:0]    PREFIX_LIM = 16'(PREFIX_BYTES);

    // Parse state.
    t_phase                  r_phase,    n_phase;
    logic [OFFSET_WIDTH-1:0] r_pos,      n_pos;
    logic [OFFSET_WIDTH-1:0] r_moff,     n_moff;
    logic [15:0]             r_fill,     n_fill;
    logic [7:0]              r_code,     n_code;
    logic [7:0]              r_len_hi,   n_len_hi;
    logic [15:0]             r_pay_rem,  n_pay_rem;
    logic [PW-1:0]           r_pre_rem,  n_pre_rem;
    logic [15:0]             r_segs,     n_segs;
    logic                    r_seen_soi, n_seen_soi;
    logic                    r_stopped,  n_stopped;

    // Result register.
    logic    r_res_valid;
    t_result r_res;

    logic                    fire;
    logic                    res_fire;
    t_result                 res;
    logic [7:0]              b;
    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic [31:0]             pos32;
    logic [31:0]             pos_inc32;
    logic [31:0]             moff32;
    logic [15:0]             length;
    logic [15:0]             plen;
    logic [CW-1:0]           poff_ext;
    logic [CW-1:0]           room_ext;
    logic                    trunc;
    logic [15:0]             pay_dec;
    logic [PW-1:0]           pre_dec;

    function automatic t_result err_res(t_status st, logic [31:0] moff, logic [15:0] idx);
        t_result r;
        r                 = '0;
        r.kind            = KIND_ERROR;
        r.marker_offset   = moff;
        r.last_of_segment = 1'b1;
        r.status          = st;
        r.segment_index   = idx;
        return r;
    endfunction

    function automatic logic is_alone(logic [7:0] c);
        return ((c >= MK_RST0) && (c <= MK_RST7)) || (c == MK_SOI) || (c == MK_EOI) ||
               (c == MK_TEM);
    endfunction

    assign o_item_ready = !r_res_valid || i_res_ready;
    assign fire         = i_item_valid && o_item_ready;

    // Offsets and the payload bounds check against the file size.
    assign b         = i_item.byte_value;
    assign pos_inc   = r_pos + OFFSET_WIDTH'(1);
    assign pos32     = 32'(r_pos);
    assign pos_inc32 = 32'(pos_inc);
    assign moff32    = 32'(r_moff);
    assign length    = {r_len_hi, b};
    assign plen      = length - LEN_FIELD_BYTES;
    assign poff_ext  = CW'(pos_inc);
    assign room_ext  = CW'(i_cfg.file_size - 32'(plen));
    assign trunc     = (32'(plen) > i_cfg.file_size) || (poff_ext > room_ext);
    assign pay_dec   = r_pay_rem - 16'd1;
    assign pre_dec   = r_pre_rem - PW'(1);

    // Step logic for one accepted byte or end beat.
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_moff     = r_moff;
        n_fill     = r_fill;
        n_code     = r_code;
        n_len_hi   = r_len_hi;
        n_pay_rem  = r_pay_rem;
        n_pre_rem  = r_pre_rem;
        n_segs     = r_segs;
        n_seen_soi = r_seen_soi;
        n_stopped  = r_stopped;
        res_fire   = 1'b0;
        res        = '0;

        if (!r_stopped) begin
            if (r_phase == PH_PREFIX) begin
                // A new marker starts at the current position.
                n_moff = r_pos;
                if (r_segs >= i_cfg.max_segments) begin
                    res_fire  = 1'b1;
                    res       = err_res(ST_MALFORMED, pos32, r_segs);
                    n_stopped = 1'b1;
                end else if (i_item.end_of_data) begin
                    res_fire  = 1'b1;
                    res       = err_res(t_status'(r_seen_soi ? ST_TRUNCATED : ST_NOT_JPEG),
                                        pos32, r_segs);
                    n_stopped = 1'b1;
                end else begin
                    n_pos = pos_inc;
                    if (b != MK_PREFIX) begin
                        res_fire  = 1'b1;
                        res       = err_res(ST_MALFORMED, pos32, r_segs);
                        n_stopped = 1'b1;
                    end else begin
                        n_fill  = '0;
                        n_phase = PH_CODE;
                    end
                end
            end else if (i_item.end_of_data) begin
                res_fire  = 1'b1;
                res       = err_res(ST_TRUNCATED, moff32, r_segs);
                n_stopped = 1'b1;
            end else begin
                n_pos = pos_inc;
                unique case (r_phase)
                    PH_CODE: begin
                        // Fill bytes, then the code itself.
                        if (b == MK_PREFIX) begin
                            if (r_fill >= i_cfg.max_fill) begin
                                res_fire  = 1'b1;
                                res       = err_res(ST_MALFORMED, moff32, r_segs);
                                n_stopped = 1'b1;
                            end else begin
                                n_fill = r_fill + 16'd1;
                            end
                        end else if (b == MK_STUFF) begin
                            res_fire  = 1'b1;
                            res       = err_res(ST_MALFORMED, moff32, r_segs);
                            n_stopped = 1'b1;
                        end else if ((r_segs == 16'd0) && (b != MK_SOI)) begin
                            res_fire  = 1'b1;
                            res       = err_res(ST_NOT_JPEG, moff32, r_segs);
                            n_stopped = 1'b1;
                        end else begin
                            if (b == MK_SOI) begin
                                n_seen_soi = 1'b1;
                            end
                            n_code = b;
                            if (is_alone(b)) begin
                                res_fire              = 1'b1;
                                res.kind              = KIND_HEADER;
                                res.marker_code       = b;
                                res.marker_offset     = moff32;
                                res.fill_count        = r_fill;
                                res.is_standalone     = 1'b1;
                                res.payload_offset    = pos_inc32;
                                res.last_of_segment   = 1'b1;
                                res.status            = ST_OK;
                                res.segment_index     = r_segs;
                                n_segs                = r_segs + 16'd1;
                                n_stopped             = (b == MK_EOI);
                                n_phase               = PH_PREFIX;
                            end else begin
                                n_phase = PH_LEN_HI;
                            end
                        end
                    end
                    PH_LEN_HI: begin
                        n_len_hi = b;
                        n_phase  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        // Length complete: check it, then emit the header or an error.
                        if (length < LEN_FIELD_BYTES) begin
                            res_fire  = 1'b1;
                            res       = err_res(ST_MALFORMED, moff32, r_segs);
                            n_stopped = 1'b1;
                        end else if (trunc) begin
                            res_fire  = 1'b1;
                            res       = err_res(ST_TRUNCATED, moff32, r_segs);
                            n_stopped = 1'b1;
                        end else begin
                            res_fire            = 1'b1;
                            res.kind            = KIND_HEADER;
                            res.marker_code     = r_code;
                            res.marker_offset   = moff32;
                            res.fill_count      = r_fill;
                            res.payload_length  = plen;
                            res.payload_offset  = pos_inc32;
                            res.scan_length     = (r_code == MK_SOS) ?
                                                  (i_cfg.file_size - pos_inc32 - 32'(plen)) :
                                                  32'd0;
                            res.last_of_segment = (plen == 16'd0);
                            res.status          = ST_OK;
                            res.segment_index   = r_segs;
                            n_segs              = r_segs + 16'd1;
                            if (plen == 16'd0) begin
                                n_stopped = (r_code == MK_SOS);
                                n_phase   = PH_PREFIX;
                            end else begin
                                n_pay_rem = plen;
                                n_pre_rem = (plen < PREFIX_LIM) ? PW'(plen) : PREFIX_CNT;
                                n_phase   = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        // Leading payload bytes are reported, the rest skipped.
                        if (r_pre_rem != '0) begin
                            n_pre_rem           = pre_dec;
                            res_fire            = 1'b1;
                            res.kind            = KIND_PREFIX;
                            res.marker_code     = r_code;
                            res.marker_offset   = moff32;
                            res.fill_count      = r_fill;
                            res.prefix_byte     = b;
                            res.last_of_segment = (pre_dec == '0);
                            res.status          = ST_OK;
                            res.segment_index   = r_segs - 16'd1;
                        end
                        if (r_pay_rem <= 16'd1) begin
                            n_pay_rem = '0;
                            n_stopped = (r_code == MK_SOS);
                            n_phase   = PH_PREFIX;
                        end else begin
                            n_pay_rem = pay_dec;
                        end
                    end
                    default: begin
                        n_phase = PH_PREFIX;
                    end
                endcase
            end
        end
    end

    // State registers; a file size write restarts the parse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_phase    <= PH_PREFIX;
            r_pos      <= '0;
            r_moff     <= '0;
            r_fill     <= '0;
            r_code     <= '0;
            r_len_hi   <= '0;
            r_pay_rem  <= '0;
            r_pre_rem  <= '0;
            r_segs     <= '0;
            r_seen_soi <= 1'b0;
            r_stopped  <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_moff     <= n_moff;
            r_fill     <= n_fill;
            r_code     <= n_code;
            r_len_hi   <= n_len_hi;
            r_pay_rem  <= n_pay_rem;
            r_pre_rem  <= n_pre_rem;
            r_segs     <= n_segs;
            r_seen_soi <= n_seen_soi;
            r_stopped  <= n_stopped;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (fire && res_fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (fire && res_fire) begin
            r_res <= res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A stopped parser never produces a result.
    `ASSERT_IMPL(a_stopped_silent, r_stopped, !res_fire, "result from a stopped parser")

    // Prefix bytes remain only while a payload is being walked.
    `ASSERT_IMPL(a_prefix_in_payload, r_pre_rem != '0, r_phase == PH_PAYLOAD,
                 "prefix count outside payload")

    // Every error stops the parser.
    `ASSERT_NEXT(a_error_stops, fire && res_fire && (res.kind == KIND_ERROR) &&
                 !i_cfg.restart, r_stopped, "parser still running after an error")

endmodule

// ----- hdl/jpeg_marker_segment_parser_core.sv -----
// ============================================================================
// jpeg_marker_segment_parser_core
// Walks a JPEG byte stream and reports marker segment headers, payload
// prefix bytes and error statuses.
// ============================================================================
//
//  Channel  Direction  Handshake                 Beat
//  in       sink       i_in_valid / o_in_ready   one file byte or an end mark
//  out      source     o_out_valid / i_out_ready zero or one result per in beat
//  cfg      sink       i_cfg_valid / o_cfg_ready register index and data
//
//  One in beat is taken every cycle while the result side keeps up.
//  A beat reaches its result through the input register, then the step
//  logic into the result register.
//  Reset is synchronous and active low; it clears parse state and restores
//  max_fill to 64 and max_segments to 256. A file_size write restarts parsing.
//  A stalled result holds the result register, which backs up the input
//  register and then drops o_in_ready.
//
module jpeg_marker_segment_parser_core
    import jmsp_pkg::*;
#(
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_marker_code,
    output logic [31:0] o_marker_offset,
    output logic [15:0] o_fill_count,
    output logic        o_is_standalone,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_payload_offset,
    output logic [31:0] o_scan_length,
    output logic [7:0]  o_prefix_byte,
    output logic        o_last_of_segment,
    output logic [1:0]  o_status,
    output logic [15:0] o_segment_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_item r_in;
    logic     item_ready;
    t_result  res;

    // Configuration is always writable.
    assign o_cfg_ready = 1'b1;

    jmsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register; it refills in the cycle it hands its beat on.
    assign o_in_ready = !r_in_valid || item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.byte_value  <= i_byte_value;
            r_in.end_of_data <= i_end_of_data;
        end
    end

    jmsp_parser #(
        .PREFIX_BYTES (PREFIX_BYTES),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_item_ready (item_ready),
        .o_res_valid  (o_out_valid),
        .o_res        (res),
        .i_res_ready  (i_out_ready)
    );

    // Result fields onto their ports.
    assign o_kind            = res.kind;
    assign o_marker_code     = res.marker_code;
    assign o_marker_offset   = res.marker_offset;
    assign o_fill_count      = res.fill_count;
    assign o_is_standalone   = res.is_standalone;
    assign o_payload_length  = res.payload_length;
    assign o_payload_offset  = res.payload_offset;
    assign o_scan_length     = res.scan_length;
    assign o_prefix_byte     = res.prefix_byte;
    assign o_last_of_segment = res.last_of_segment;
    assign o_status          = res.status;
    assign o_segment_index   = res.segment_index;

endmodule
